/* rtl/tbo_pkg.sv */
// Shared constants and types for the toroidal block occupancy lattice.
package tbo_pkg;

  localparam int GRID_X        = 64;
  localparam int GRID_Y        = 64;
  localparam int MAX_HALF_SIZE = 7;
  localparam int LABEL_BITS    = 16;

  localparam int XW        = $clog2(GRID_X);
  localparam int YW        = $clog2(GRID_Y);
  localparam int CELLS     = GRID_X * GRID_Y;
  localparam int ADDR_BITS = $clog2(CELLS);
  localparam int HW        = $clog2(MAX_HALF_SIZE + 1);
  localparam int SW        = $clog2(2 * MAX_HALF_SIZE + 1);

  typedef enum logic [1:0] {
    MODE_EMPTY  = 2'd0,
    MODE_OWNER  = 2'd1,
    MODE_FILL   = 2'd2,
    MODE_BOUNDS = 2'd3
  } mode_e;

  // One access to the lattice memory
  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  addr;
    logic [LABEL_BITS-1:0] wdata;
  } lat_req_t;

endpackage

/* rtl/tbo_lattice.sv */
// Single-port lattice memory of cell labels with registered read data.
module tbo_lattice (
  input  logic                            clk_i,
  input  tbo_pkg::lat_req_t               req_i,
  output logic [tbo_pkg::LABEL_BITS-1:0]  rdata_o
);
  import tbo_pkg::*;

  logic [LABEL_BITS-1:0] mem_q [CELLS];
  logic [LABEL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/toroidal_block_occupancy.sv */
// Top level: sequencer that scans or fills a square block of the toroidal lattice.
//
// After reset the block sweeps the lattice to zero, one cell per cycle, over all
// GRID_X*GRID_Y cells; in_ready_o stays low until the sweep is done. A check or
// fill request then visits the (2h+1) by (2h+1) block, h being the half size capped at
// MAX_HALF_SIZE, one cell per cycle on the single-port lattice memory. A bounds request
// (mode 3) does no scan of the lattice. One request is worked on at a time; the result
// sits in an output register while the next request is taken.
module toroidal_block_occupancy (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      mode_i,
  input  logic [5:0]                      center_x_i,
  input  logic [5:0]                      center_y_i,
  input  logic [2:0]                      half_size_i,
  input  logic [15:0]                     label_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            result_flag_o
);
  import tbo_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [ADDR_BITS-1:0]  clr_q, clr_d;
  mode_e                 mode_q, mode_d;
  logic [LABEL_BITS-1:0] label_q, label_d;
  logic [XW-1:0]         x_q, x_d;
  logic [YW-1:0]         y_q, y_d, y_start_q, y_start_d;
  logic [SW-1:0]         dx_q, dx_d, dy_q, dy_d, last_q, last_d;
  logic                  flag_q, flag_d;
  logic                  rd_pend_q, rd_pend_d;
  logic                  out_valid_q, out_valid_d;
  logic                  result_q, result_d;

  lat_req_t              lat_req;
  logic [LABEL_BITS-1:0] lat_rdata;
  logic                  in_fire;
  logic                  cell_busy;
  logic [HW-1:0]         h_sat;
  int                    cx_w, cy_w, sx, sy;
  logic                  in_bounds;

  tbo_lattice u_lattice (
    .clk_i   (clk_i),
    .req_i   (lat_req),
    .rdata_o (lat_rdata)
  );

  assign in_ready_o    = (state_q == ST_IDLE);
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign result_flag_o = result_q;

  // Start corner of the block, wrapped onto the torus
  always_comb begin
    h_sat = (int'(half_size_i) > MAX_HALF_SIZE) ? HW'(MAX_HALF_SIZE) : HW'(half_size_i);
    cx_w  = (int'(center_x_i) >= GRID_X) ? int'(center_x_i) - GRID_X : int'(center_x_i);
    cy_w  = (int'(center_y_i) >= GRID_Y) ? int'(center_y_i) - GRID_Y : int'(center_y_i);
    sx    = cx_w - int'(h_sat);
    sy    = cy_w - int'(h_sat);
    if (sx < 0) begin
      sx = sx + GRID_X;
    end
    if (sy < 0) begin
      sy = sy + GRID_Y;
    end
    // bounds mode uses the raw centre
    in_bounds = !((int'(center_x_i) < int'(h_sat)) ||
                  (int'(center_x_i) + int'(h_sat) >= GRID_X) ||
                  (int'(center_y_i) < int'(h_sat)) ||
                  (int'(center_y_i) + int'(h_sat) >= GRID_Y));
  end

  // Occupied by someone other than the owner (or at all, for the empty check)
  assign cell_busy = (lat_rdata != '0) && ((mode_q == MODE_EMPTY) || (lat_rdata != label_q));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    label_d     = label_q;
    x_d         = x_q;
    y_d         = y_q;
    y_start_d   = y_start_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    last_d      = last_q;
    flag_d      = flag_q;
    rd_pend_d   = 1'b0;
    out_valid_d = out_valid_q;
    result_d    = result_q;

    lat_req.we    = 1'b0;
    lat_req.addr  = ADDR_BITS'(x_q) * ADDR_BITS'(GRID_Y) + ADDR_BITS'(y_q);
    lat_req.wdata = label_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (rd_pend_q && cell_busy) begin
      flag_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        lat_req.we    = 1'b1;
        lat_req.addr  = clr_q;
        lat_req.wdata = '0;
        clr_d         = clr_q + 1'b1;
        if (clr_q == ADDR_BITS'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          mode_d    = mode_e'(mode_i);
          label_d   = LABEL_BITS'(label_i);
          x_d       = XW'(sx);
          y_d       = YW'(sy);
          y_start_d = YW'(sy);
          dx_d      = '0;
          dy_d      = '0;
          last_d    = SW'({h_sat, 1'b0});
          if (mode_e'(mode_i) == MODE_BOUNDS) begin
            flag_d  = in_bounds;
            state_d = ST_FINISH;
          end else begin
            flag_d  = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        lat_req.we = (mode_q == MODE_FILL);
        rd_pend_d  = (mode_q != MODE_FILL);
        if (dy_q == last_q) begin
          dy_d = '0;
          y_d  = y_start_q;
          dx_d = dx_q + 1'b1;
          x_d  = (x_q == XW'(GRID_X - 1)) ? '0 : x_q + 1'b1;
          if (dx_q == last_q) begin
            state_d = ST_DRAIN;
          end
        end else begin
          dy_d = dy_q + 1'b1;
          y_d  = (y_q == YW'(GRID_Y - 1)) ? '0 : y_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last read data is checked this cycle
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          result_d    = flag_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    label_q   <= label_d;
    x_q       <= x_d;
    y_q       <= y_d;
    y_start_q <= y_start_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    last_q    <= last_d;
    flag_q    <= flag_d;
    result_q  <= result_d;
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_scan_not_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (mode_q != MODE_BOUNDS))
    else $error("bounds request entered the lattice scan");

  a_fill_always_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && mode_q == MODE_FILL) |-> flag_q)
    else $error("fill request produced a zero flag");

  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("pending read outside of a scan");
`endif

endmodule

/* tb/tbo_checker.sv */
// Checker for the block occupancy lattice: predicts each result flag and compares it.
module tbo_checker
  import tbo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  center_x_i,
  input  logic [5:0]  center_y_i,
  input  logic [2:0]  half_size_i,
  input  logic [15:0] label_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic        result_flag_o,
  output int          err_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LABEL_BITS-1:0] lattice_q [CELLS];
  bit                    awaited_flags [$];
  int                    errors;
  bit                    want;
  bit                    predicted;

  // Applies one request to the lattice copy and returns the flag it yields.
  function automatic bit block_outcome(input mode_e m, input int cx, input int cy,
                                       input int hs, input logic [LABEL_BITS-1:0] lbl);
    int i;
    int j;
    int idx;
    bit flag;
    flag = 1'b1;
    if (hs > MAX_HALF_SIZE) hs = MAX_HALF_SIZE;
    if (m == MODE_BOUNDS) begin
      // raw centre, no wrap
      if (cx - hs < 0 || cx + hs >= GRID_X || cy - hs < 0 || cy + hs >= GRID_Y)
        flag = 1'b0;
    end else begin
      for (int dx = -hs; dx <= hs; dx++) begin
        for (int dy = -hs; dy <= hs; dy++) begin
          i   = (cx + dx + GRID_X) % GRID_X;
          j   = (cy + dy + GRID_Y) % GRID_Y;
          idx = i * GRID_Y + j;
          if (m == MODE_FILL) begin
            lattice_q[idx] = lbl;
          end else if (lattice_q[idx] != '0 && (m == MODE_EMPTY || lattice_q[idx] != lbl)) begin
            flag = 1'b0;
          end
        end
      end
    end
    return flag;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CELLS; k++) lattice_q[k] = '0;
      awaited_flags.delete();
      errors = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // retire results before taking the new request: a result never belongs to it
      if (out_valid_o && out_ready_i) begin
        if (awaited_flags.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no request outstanding, flag %b", $time, result_flag_o);
        end else begin
          want = awaited_flags.pop_front();
          if (result_flag_o !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result_flag mismatch, expected %0b got %b",
                       $time, want, result_flag_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted = block_outcome(mode_e'(mode_i), int'(center_x_i),
                                  int'(center_y_i), int'(half_size_i), label_i);
        awaited_flags.insert(awaited_flags.size(), predicted);
      end
      err_cnt_o <= errors;
      pending_o <= awaited_flags.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top: drives lattice requests under varying back-pressure and gives the verdict.
module tb_top;
  import tbo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 600;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i        = '0;
  logic [5:0]  center_x_i    = '0;
  logic [5:0]  center_y_i    = '0;
  logic [2:0]  half_size_i   = '0;
  logic [15:0] label_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        result_flag_o;

  int err_cnt;
  int pending;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_req     = 1'b0;

  toroidal_block_occupancy uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .half_size_i   (half_size_i),
    .label_i       (label_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_flag_o (result_flag_o)
  );

  tbo_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .half_size_i   (half_size_i),
    .label_i       (label_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_flag_o (result_flag_o),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_req(input mode_e m, input logic [5:0] cx, input logic [5:0] cy,
                          input logic [2:0] hs, input logic [15:0] lbl);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    center_x_i  <= cx;
    center_y_i  <= cy;
    half_size_i <= hs;
    label_i     <= lbl;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  initial begin
    #(20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    mode_e       m;
    logic [5:0]  cx;
    logic [5:0]  cy;
    logic [2:0]  hs;
    logic [15:0] lbl;
    logic [5:0]  last_x;
    logic [5:0]  last_y;
    logic [15:0] last_lbl;
    int          r;

    last_x   = 6'd32;
    last_y   = 6'd32;
    last_lbl = 16'd1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 11;
    snk_idle_pct = 84;

    // directed: wrap at the corners, bounds edges, label extremes, owner zero, clears
    send_req(MODE_EMPTY,  6'd0,  6'd0,  3'd7, 16'h0000);
    send_req(MODE_BOUNDS, 6'd7,  6'd7,  3'd7, 16'h0000);
    send_req(MODE_BOUNDS, 6'd6,  6'd7,  3'd7, 16'hFFFF);
    send_req(MODE_BOUNDS, 6'd56, 6'd56, 3'd7, 16'h0000);
    send_req(MODE_BOUNDS, 6'd56, 6'd57, 3'd7, 16'h0000);
    send_req(MODE_BOUNDS, 6'd63, 6'd63, 3'd0, 16'h0000);
    send_req(MODE_BOUNDS, 6'd0,  6'd0,  3'd0, 16'h0000);
    send_req(MODE_FILL,   6'd63, 6'd63, 3'd7, 16'hFFFF);
    send_req(MODE_EMPTY,  6'd5,  6'd5,  3'd1, 16'h0000);
    send_req(MODE_OWNER,  6'd5,  6'd5,  3'd1, 16'hFFFF);
    send_req(MODE_OWNER,  6'd5,  6'd5,  3'd1, 16'h7FFF);
    send_req(MODE_OWNER,  6'd0,  6'd0,  3'd0, 16'h0000);
    send_req(MODE_OWNER,  6'd32, 6'd32, 3'd3, 16'h0000);
    send_req(MODE_FILL,   6'd63, 6'd63, 3'd7, 16'h0000);
    send_req(MODE_EMPTY,  6'd0,  6'd0,  3'd7, 16'h0000);
    send_req(MODE_FILL,   6'd32, 6'd32, 3'd0, 16'hAAAA);
    send_req(MODE_OWNER,  6'd32, 6'd32, 3'd2, 16'hAAAA);
    send_req(MODE_OWNER,  6'd32, 6'd32, 3'd2, 16'h5555);
    send_req(MODE_EMPTY,  6'd33, 6'd33, 3'd0, 16'h0000);
    send_req(MODE_FILL,   6'd33, 6'd32, 3'd1, 16'h5555);
    send_req(MODE_OWNER,  6'd32, 6'd32, 3'd0, 16'h5555);
    send_req(MODE_FILL,   6'd32, 6'd32, 3'd7, 16'h0000);
    send_req(MODE_EMPTY,  6'd32, 6'd32, 3'd7, 16'h0000);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        src_idle_pct = 84;
        snk_idle_pct = 11;
      end else if (ph == 2) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b1;
      end
      for (int n = 0; n < ((ph == 2) ? 550 : 500); n++) begin
        r = $urandom_range(0, 99);
        if (r < 30)      m = MODE_FILL;
        else if (r < 55) m = MODE_OWNER;
        else if (r < 80) m = MODE_EMPTY;
        else             m = MODE_BOUNDS;
        hs = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
        r = $urandom_range(0, 9);
        if (r < 3)       lbl = 16'h0000;
        else if (r < 8)  lbl = 16'($urandom_range(1, 4));
        else if (r == 8) lbl = 16'hFFFF;
        else             lbl = 16'($urandom);
        // mostly work around the latest fill so owner checks see matching labels
        if (m != MODE_BOUNDS && $urandom_range(0, 99) < 60) begin
          cx = last_x + 6'($urandom_range(0, 4)) - 6'd2;
          cy = last_y + 6'($urandom_range(0, 4)) - 6'd2;
          if ($urandom_range(0, 3) != 0) lbl = last_lbl;
        end else begin
          cx = 6'($urandom);
          cy = 6'($urandom);
        end
        if (m == MODE_FILL) begin
          last_x = cx;
          last_y = cy;
          if (lbl != 16'h0000) last_lbl = lbl;
        end
        send_req(m, cx, cy, hs, lbl);
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
